// ----- sv/rfd_pkg.sv -----
package rfd_pkg;

  localparam int unsigned FrameMax = 65536;
  localparam int unsigned IdxW     = $clog2(FrameMax + 1);
  localparam int unsigned CfgW     = 17;
  localparam int unsigned CmpW     = (IdxW > CfgW) ? IdxW : CfgW;
  localparam int unsigned RunW     = 7;

  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChHash   = 8'h23;

  localparam logic [5:0] SymDollar   = 6'd62;
  localparam logic [5:0] SymHash     = 6'd63;
  localparam logic [5:0] UpperOffset = 6'd10;
  localparam logic [5:0] LowerOffset = 6'd36;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [RunW-1:0] run_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] pixel_index;
    logic [5:0]  color;
    logic        last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic       clear;
    logic       launch;
    logic [5:0] color;
    run_t       run_len;
  } run_cmd_t;

  function automatic logic [5:0] symbol_of(input logic [7:0] ch);
    logic [7:0] diff;
    diff = 8'd0;
    if (ch >= ChDigit0 && ch <= ChDigit9) begin
      diff = ch - ChDigit0;
      return diff[5:0];
    end else if (ch >= ChUpperA && ch <= ChUpperZ) begin
      diff = ch - ChUpperA;
      return diff[5:0] + UpperOffset;
    end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
      diff = ch - ChLowerA;
      return diff[5:0] + LowerOffset;
    end else if (ch == ChDollar) begin
      return SymDollar;
    end else if (ch == ChHash) begin
      return SymHash;
    end
    return 6'd0;
  endfunction

endpackage

// ----- sv/rfd_run_unit.sv -----
module rfd_run_unit
  import rfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  run_cmd_t  cmd_i,
  input  idx_t      limit_i,
  input  logic      advance_i,
  output logic      busy_o,
  output logic      beat_valid_o,
  output out_beat_t beat_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e     state_q, state_d;
  run_t       remain_q, remain_d;
  idx_t       idx_q, idx_d;
  logic [5:0] color_q, color_d;

  logic          can_write;
  logic          step;
  logic [IdxW:0] idx_next;
  logic [31:0]   idx_wide;

  assign can_write = (remain_q != '0) && (CmpW'(idx_q) < CmpW'(limit_i));
  assign step      = (state_q == StRun) && can_write && advance_i;
  assign idx_next  = {1'b0, idx_q} + (IdxW + 1)'(1);
  assign idx_wide  = 32'(idx_q);

  assign busy_o       = (state_q == StRun);
  assign beat_valid_o = step;
  assign beat_o.pixel_index = idx_wide[15:0];
  assign beat_o.color       = color_q;
  assign beat_o.last_of_run = (remain_q == run_t'(1)) ||
                              (idx_next == (IdxW + 1)'(limit_i));

  always_comb begin
    state_d  = state_q;
    remain_d = remain_q;
    idx_d    = idx_q;
    color_d  = color_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_i.clear) begin
          idx_d = '0;
        end
        if (cmd_i.launch) begin
          remain_d = cmd_i.run_len;
          color_d  = cmd_i.color;
          state_d  = StRun;
        end
      end
      StRun: begin
        if (!can_write) begin
          state_d = StIdle;
        end else if (step) begin
          remain_d = remain_q - run_t'(1);
          idx_d    = idx_next[IdxW-1:0];
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      remain_q <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

endmodule

// ----- sv/rle_frame_decoder.sv -----
// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_stall_o   in_beat_t (char_code, frame_start)
// out      source     out_valid_o/out_stall_i out_beat_t (pixel_index, color, last_of_run)
// cfg      sink       cfg_valid_i/cfg_ready_o 17-bit frame_pixels
//
// A colour character is accepted without stalling in. A run character is accepted,
// then writes up to 64 pixels, counted down by the remaining-run counter in
// rfd_run_unit, and in stays stalled until the run closes; out stalls hold the writes.
// Reset clears the index, the pending colour and frame_pixels to zero.
// in_stall_o and cfg_ready_o follow the run unit's busy state.
module rle_frame_decoder
  import rfd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_beat_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_beat_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  logic [CfgW-1:0] frame_pixels_q;
  logic [5:0]      pending_q, pending_d;
  logic            have_q, have_d;
  logic            out_valid_q;
  out_beat_t       out_q;

  logic       busy;
  logic       in_fire;
  logic       advance;
  logic       have_eff;
  logic [5:0] sym;
  idx_t       limit;
  run_cmd_t   cmd;
  logic       beat_valid;
  out_beat_t  beat;

  assign in_stall_o  = busy;
  assign cfg_ready_o = !busy;
  assign in_fire     = in_valid_i && !busy;
  assign advance     = !out_valid_q || !out_stall_i;
  assign sym         = symbol_of(in_data_i.char_code);
  assign have_eff    = have_q && !in_data_i.frame_start;

  assign limit = (CmpW'(frame_pixels_q) > CmpW'(FrameMax)) ?
                 IdxW'(FrameMax) : IdxW'(frame_pixels_q);

  always_comb begin
    pending_d   = pending_q;
    have_d      = have_q;
    cmd.clear   = in_fire && in_data_i.frame_start;
    cmd.launch  = 1'b0;
    cmd.color   = pending_q;
    cmd.run_len = run_t'(sym) + run_t'(1);
    if (in_fire) begin
      if (!have_eff) begin
        pending_d = sym;
        have_d    = 1'b1;
      end else begin
        have_d     = 1'b0;
        cmd.launch = 1'b1;
      end
    end
  end

  rfd_run_unit u_run (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .limit_i      (limit),
    .advance_i    (advance),
    .busy_o       (busy),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= '0;
      pending_q      <= '0;
      have_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      pending_q <= pending_d;
      have_q    <= have_d;
      if (cfg_valid_i && cfg_ready_o) begin
        frame_pixels_q <= cfg_data_i;
      end
      if (advance) begin
        out_valid_q <= beat_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && beat_valid) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
